@@ design/knob_range_calibrate_and_map_macros.svh @@
// ----------------------------------------------------------------------------
// knob range calibration: assertion macros
// immediate-implication and next-cycle-implication forms, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef KNOB_RANGE_CALIBRATE_AND_MAP_MACROS_SVH
`define KNOB_RANGE_CALIBRATE_AND_MAP_MACROS_SVH

`ifndef SYNTHESIS

`define KBCAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define KBCAL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KBCAL_ASSERT_IMP(label, ante, cons, msg)

`define KBCAL_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ design/kbcal_pkg.sv @@
// ----------------------------------------------------------------------------
// kbcal_pkg
// types and constants shared by the knob range calibration block
// ----------------------------------------------------------------------------
package kbcal_pkg;

    localparam int ADC_BITS = 10;
    localparam int WIN_W    = 32;
    localparam int LIM_W    = 12;   // signed limits, hold the presets
    localparam int SPAN_W   = 11;   // signed span
    localparam int DIFF_W   = LIM_W + 1;
    localparam int SCALE_W  = 8;
    localparam int NUM_W    = DIFF_W - 1 + SCALE_W;  // dividend magnitude
    localparam int DEN_W    = SPAN_W;                // divisor magnitude
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [NUM_W-1:0] SCALE = NUM_W'(255);
    localparam logic signed [LIM_W-1:0] PRESET_LOW  = LIM_W'(2000);
    localparam logic signed [LIM_W-1:0] PRESET_HIGH = -LIM_W'(1000);
    localparam logic [ADC_BITS-1:0] OK_LOW_MAX  = ADC_BITS'(50);
    localparam logic [ADC_BITS-1:0] OK_HIGH_MIN = ADC_BITS'(970);
    localparam logic [ADC_BITS-1:0] OK_HIGH_MAX = ADC_BITS'(1023);
    localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(9000);
    localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(32767);
    localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(32768);

    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_CAL     = 2'd1,
        CMD_RESTORE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARM   = 2'd1,
        PH_TRACK = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 2'd0,
        CFG_STORED_LO = 2'd1,
        CFG_STORED_HI = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic signed [OUT_W-1:0] mapped_value;
        logic                    is_calibrated;
        logic                    save_request;
        logic [ADC_BITS-1:0]     limit_low;
        logic [ADC_BITS-1:0]     limit_high;
        logic [1:0]              cal_phase;
        logic                    range_zero;
    } t_res;

    // divider handshake towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ design/kbcal_in_if.sv @@
// ----------------------------------------------------------------------------
// kbcal_in_if
// input channel: command, sample and timestamp words
// ----------------------------------------------------------------------------
interface kbcal_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic [kbcal_pkg::ADC_BITS-1:0]    sample;
    logic [kbcal_pkg::WIN_W-1:0]       now_ms;

    modport source (output valid, output command, output sample, output now_ms,
                    input ready);
    modport sink   (input valid, input command, input sample, input now_ms,
                    output ready);
endinterface

@@ design/kbcal_out_if.sv @@
// ----------------------------------------------------------------------------
// kbcal_out_if
// result channel: mapped position and calibration status words
// ----------------------------------------------------------------------------
interface kbcal_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [kbcal_pkg::OUT_W-1:0]     mapped_value;
    logic                                   is_calibrated;
    logic                                   save_request;
    logic [kbcal_pkg::ADC_BITS-1:0]         limit_low;
    logic [kbcal_pkg::ADC_BITS-1:0]         limit_high;
    logic [1:0]                             cal_phase;
    logic                                   range_zero;

    modport source (output valid, output mapped_value, output is_calibrated,
                    output save_request, output limit_low, output limit_high,
                    output cal_phase, output range_zero, input ready);
    modport sink   (input valid, input mapped_value, input is_calibrated,
                    input save_request, input limit_low, input limit_high,
                    input cal_phase, input range_zero, output ready);
endinterface

@@ design/kbcal_div.sv @@
// ----------------------------------------------------------------------------
// kbcal_div
// restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kbcal_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [kbcal_pkg::NUM_W-1:0]      i_dividend,
    input  logic [kbcal_pkg::DEN_W-1:0]      i_divisor,
    output kbcal_pkg::t_div_stat             o_stat,
    output logic [kbcal_pkg::NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(kbcal_pkg::NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(kbcal_pkg::NUM_W - 1);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [kbcal_pkg::NUM_W-1:0]   r_quot, n_quot;
    logic [kbcal_pkg::DEN_W-1:0]   r_rem, n_rem;
    logic [kbcal_pkg::DEN_W-1:0]   r_den, n_den;
    logic [kbcal_pkg::DEN_W:0]     trial;
    logic [kbcal_pkg::DEN_W:0]     diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_quot[kbcal_pkg::NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the trial fits one bit more
            if (trial >= {1'b0, r_den}) begin
                n_rem  = diff[kbcal_pkg::DEN_W-1:0];
                n_quot = {r_quot[kbcal_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem  = trial[kbcal_pkg::DEN_W-1:0];
                n_quot = {r_quot[kbcal_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
endmodule

@@ design/knob_range_calibrate_and_map.sv @@
// ----------------------------------------------------------------------------
// knob_range_calibrate_and_map
// learns the usable travel of an analogue knob and maps samples so that this travel spans 0..255
// ----------------------------------------------------------------------------
// One word in gives one word out. A start command arms a calibration; the
// next sample opens a timed window and presets the limits, later samples
// widen them until the elapsed time (32-bit wrapping) exceeds cal_window_ms,
// and the sample after that reports a save request with the limits. A
// restore command loads stored_min/stored_max and marks the knob calibrated
// when they lie in the accepted bands. When calibrated and idle, a sample
// maps to trunc((sample - low) * 255 / span), saturated to 16-bit signed;
// a zero span gives 0 with range_zero set. Timing: every accepted word is
// registered as a pending word and handed to the output register once
// that is free; a mapped sample first goes through the restoring divider
// at one quotient bit per cycle. The input is not ready until the current
// word has reached the output register; a finished word may wait there
// while the next one is taken. Configuration writes are single-cycle; the
// user must make them only while the block is idle, as the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`include "knob_range_calibrate_and_map_macros.svh"

module knob_range_calibrate_and_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    kbcal_in_if.sink                             i_in,
    kbcal_out_if.source                          o_res,
    input  logic                                 i_cfg_we,
    input  logic [kbcal_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kbcal_pkg::CFG_W-1:0]          i_cfg_data
);
    localparam int LIM_W  = kbcal_pkg::LIM_W;
    localparam int SPAN_W = kbcal_pkg::SPAN_W;
    localparam int DIFF_W = kbcal_pkg::DIFF_W;
    localparam int NUM_W  = kbcal_pkg::NUM_W;
    localparam int ADC_W  = kbcal_pkg::ADC_BITS;

    // configuration registers
    logic [kbcal_pkg::WIN_W-1:0]   r_window;
    logic [ADC_W-1:0]              r_stored_lo;
    logic [ADC_W-1:0]              r_stored_hi;

    // calibration state
    kbcal_pkg::t_phase             r_phase, n_phase;
    logic signed [LIM_W-1:0]       r_low, n_low;
    logic signed [LIM_W-1:0]       r_high, n_high;
    logic signed [SPAN_W-1:0]      r_span, n_span;
    logic [kbcal_pkg::WIN_W-1:0]   r_wstart, n_wstart;
    logic                          r_cal, n_cal;

    // sequencer and result path
    kbcal_pkg::t_state             r_state, n_state;
    kbcal_pkg::t_res               r_pend, n_pend;
    kbcal_pkg::t_res               r_out;
    logic                          r_out_valid, n_out_valid;
    logic                          r_qneg, n_qneg;

    // decode
    logic                          in_ready;
    logic                          acc;
    logic                          do_map;
    logic                          load_out;
    logic                          div_start;
    kbcal_pkg::t_cmd               cmd;
    logic signed [LIM_W-1:0]       s_ext;
    logic signed [LIM_W-1:0]       lo_trk, hi_trk;
    logic signed [LIM_W-1:0]       span_full;
    logic [kbcal_pkg::WIN_W-1:0]   elapsed;
    logic                          win_over;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-2:0]             diff_mag;
    logic [kbcal_pkg::DEN_W-1:0]   span_mag;
    logic [NUM_W-1:0]              num_mag;
    logic                          restore_ok;
    logic                          span_zero;

    // divider
    kbcal_pkg::t_div_stat          div_stat;
    logic [NUM_W-1:0]              div_quot;
    logic signed [kbcal_pkg::OUT_W-1:0] sat_val;

    assign cmd     = kbcal_pkg::t_cmd'(i_in.command);
    assign acc     = i_in.valid && in_ready;
    assign s_ext   = signed'(LIM_W'(i_in.sample));
    assign elapsed = i_in.now_ms - r_wstart;
    assign win_over = elapsed > r_window;
    assign lo_trk  = (s_ext < r_low)  ? s_ext : r_low;
    assign hi_trk  = (s_ext > r_high) ? s_ext : r_high;
    assign span_full = hi_trk - lo_trk;
    assign span_zero = (r_span == '0);

    // magnitudes for the divider, sign kept aside
    assign diff     = {s_ext[LIM_W-1], s_ext} - {r_low[LIM_W-1], r_low};
    assign diff_mag = diff[DIFF_W-1] ? (DIFF_W-1)'(-diff) : diff[DIFF_W-2:0];
    assign span_mag = r_span[SPAN_W-1] ? kbcal_pkg::DEN_W'(-r_span)
                                       : kbcal_pkg::DEN_W'(r_span);
    assign num_mag  = NUM_W'(diff_mag) * kbcal_pkg::SCALE;

    assign restore_ok = (r_stored_lo <= kbcal_pkg::OK_LOW_MAX) &&
                        (r_stored_hi >= kbcal_pkg::OK_HIGH_MIN) &&
                        (r_stored_hi <= kbcal_pkg::OK_HIGH_MAX);

    assign do_map = (cmd == kbcal_pkg::CMD_SAMPLE) && (r_phase == kbcal_pkg::PH_IDLE) &&
                    r_cal && !span_zero;

    // saturate the signed quotient to 16 bits
    always_comb begin
        if (r_qneg) begin
            if (div_quot > kbcal_pkg::SAT_NEG) begin
                sat_val = signed'(kbcal_pkg::OUT_W'(kbcal_pkg::SAT_NEG));
            end else begin
                sat_val = -signed'(kbcal_pkg::OUT_W'(div_quot));
            end
        end else begin
            if (div_quot > kbcal_pkg::SAT_POS) begin
                sat_val = signed'(kbcal_pkg::OUT_W'(kbcal_pkg::SAT_POS));
            end else begin
                sat_val = signed'(kbcal_pkg::OUT_W'(div_quot));
            end
        end
    end

    // calibration state and pending result word
    always_comb begin
        n_phase  = r_phase;
        n_low    = r_low;
        n_high   = r_high;
        n_span   = r_span;
        n_wstart = r_wstart;
        n_cal    = r_cal;
        n_pend   = r_pend;
        n_qneg   = r_qneg;
        if (acc) begin
            n_pend.mapped_value = '0;
            n_pend.save_request = 1'b0;
            n_pend.limit_low    = '0;
            n_pend.limit_high   = '0;
            n_pend.range_zero   = 1'b0;
            case (cmd)
                kbcal_pkg::CMD_CAL: begin
                    n_phase = kbcal_pkg::PH_ARM;
                end
                kbcal_pkg::CMD_RESTORE: begin
                    n_low  = signed'(LIM_W'(r_stored_lo));
                    n_high = signed'(LIM_W'(r_stored_hi));
                    n_span = SPAN_W'({1'b0, r_stored_hi} - {1'b0, r_stored_lo});
                    n_cal  = restore_ok;
                end
                kbcal_pkg::CMD_SAMPLE: begin
                    case (r_phase)
                        kbcal_pkg::PH_ARM: begin
                            n_wstart = i_in.now_ms;
                            n_low    = kbcal_pkg::PRESET_LOW;
                            n_high   = kbcal_pkg::PRESET_HIGH;
                            n_cal    = 1'b0;
                            n_phase  = kbcal_pkg::PH_TRACK;
                        end
                        kbcal_pkg::PH_TRACK: begin
                            n_low  = lo_trk;
                            n_high = hi_trk;
                            if (win_over) begin
                                n_phase  = kbcal_pkg::PH_DONE;
                                n_span   = SPAN_W'(span_full);
                                n_wstart = i_in.now_ms;
                            end
                        end
                        kbcal_pkg::PH_DONE: begin
                            n_phase = kbcal_pkg::PH_IDLE;
                            n_cal   = 1'b1;
                            n_pend.save_request = 1'b1;
                            n_pend.limit_low    = r_low[ADC_W-1:0];
                            n_pend.limit_high   = r_high[ADC_W-1:0];
                        end
                        default: begin
                            if (r_cal && span_zero) begin
                                n_pend.range_zero = 1'b1;
                            end
                            n_qneg = diff[DIFF_W-1] ^ r_span[SPAN_W-1];
                        end
                    endcase
                end
                default: begin
                end
            endcase
            n_pend.is_calibrated = n_cal;
            n_pend.cal_phase     = n_phase;
        end else if (div_stat.done) begin
            n_pend.mapped_value = sat_val;
        end
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kbcal_pkg::ST_IDLE: begin
                if (acc) begin
                    n_state = do_map ? kbcal_pkg::ST_DIV : kbcal_pkg::ST_PUT;
                end
            end
            kbcal_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    n_state = kbcal_pkg::ST_PUT;
                end
            end
            kbcal_pkg::ST_PUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = kbcal_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kbcal_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            kbcal_pkg::ST_IDLE: begin
                in_ready  = 1'b1;
                div_start = i_in.valid && do_map;
            end
            kbcal_pkg::ST_PUT: begin
                load_out = !r_out_valid || o_res.ready;
            end
            default: begin
            end
        endcase
    end

    // output register frees the input side while a word waits downstream
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    kbcal_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num_mag),
        .i_divisor  (span_mag),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= kbcal_pkg::WINDOW_RST;
            r_stored_lo <= '0;
            r_stored_hi <= kbcal_pkg::OK_HIGH_MAX;
            r_phase     <= kbcal_pkg::PH_IDLE;
            r_low       <= '0;
            r_high      <= signed'(LIM_W'(kbcal_pkg::OK_HIGH_MAX));
            r_span      <= signed'(SPAN_W'(kbcal_pkg::OK_HIGH_MAX));
            r_wstart    <= '0;
            r_cal       <= 1'b0;
            r_state     <= kbcal_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kbcal_pkg::CFG_WINDOW:    r_window    <= i_cfg_data;
                    kbcal_pkg::CFG_STORED_LO: r_stored_lo <= i_cfg_data[ADC_W-1:0];
                    kbcal_pkg::CFG_STORED_HI: r_stored_hi <= i_cfg_data[ADC_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_phase     <= n_phase;
            r_low       <= n_low;
            r_high      <= n_high;
            r_span      <= n_span;
            r_wstart    <= n_wstart;
            r_cal       <= n_cal;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pend <= n_pend;
        r_qneg <= n_qneg;
        if (load_out) begin
            r_out <= r_pend;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_res.valid         = r_out_valid;
    assign o_res.mapped_value  = r_out.mapped_value;
    assign o_res.is_calibrated = r_out.is_calibrated;
    assign o_res.save_request  = r_out.save_request;
    assign o_res.limit_low     = r_out.limit_low;
    assign o_res.limit_high    = r_out.limit_high;
    assign o_res.cal_phase     = r_out.cal_phase;
    assign o_res.range_zero    = r_out.range_zero;

    `KBCAL_ASSERT_IMP(a_div_done_in_div, div_stat.done, r_state == kbcal_pkg::ST_DIV, "divider finished outside the divide state")
    `KBCAL_ASSERT_IMP(a_div_busy_in_div, div_stat.busy, r_state == kbcal_pkg::ST_DIV, "divider running outside the divide state")
    `KBCAL_ASSERT_NXT(a_acc_leaves_idle, acc, r_state != kbcal_pkg::ST_IDLE, "accepted word did not start the sequencer")
    `KBCAL_ASSERT_IMP(a_save_is_final, r_out_valid && r_out.save_request, r_out.is_calibrated && r_out.cal_phase == kbcal_pkg::PH_IDLE, "save request without a finished calibration")
    `KBCAL_ASSERT_IMP(a_zero_gives_zero, r_out_valid && r_out.range_zero, r_out.mapped_value == '0, "zero span with a non-zero position")
endmodule
